@@ src/uhc_pkg.sv @@
// Shared constants, types and helper functions of the USB host controller register bank.
package uhc_pkg;

   localparam int MAX_PORTS  = 15;
   localparam int PLAIN_REGS = 20;
   localparam int RAM_DEPTH  = PLAIN_REGS + MAX_PORTS;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);
   localparam int PC_W       = 4;
   localparam int DATA_W     = 32;
   localparam int OFF_W      = 12;
   localparam int IDX_W      = OFF_W - 2;

   localparam logic [OFF_W-1:0] OFF_REVISION   = 12'h000;
   localparam logic [OFF_W-1:0] OFF_FIRST_REG  = 12'h004;
   localparam logic [OFF_W-1:0] OFF_CMD_STATUS = 12'h008;
   localparam logic [OFF_W-1:0] OFF_LAST_REG   = 12'h050;
   localparam logic [OFF_W-1:0] PORT_BASE      = 12'h054;

   localparam logic [2:0] REGION_OPERATIONAL = 3'd0;
   localparam logic [3:0] WORD_BYTES         = 4'd4;
   localparam logic       OP_WRITE           = 1'b1;

   localparam logic [DATA_W-1:0] REVISION_VALUE     = 32'h0000_0010;
   localparam logic [DATA_W-1:0] FM_INTERVAL_RESET  = 32'h0000_2edf;
   localparam logic [DATA_W-1:0] LS_THRESHOLD_RESET = 32'h0000_0628;
   localparam logic [DATA_W-1:0] HUB_DESC_A_BASE    = (32'h1 << 12) | (32'h1 << 9);

   // RAM word addresses of the registers that do not reset to zero.
   localparam logic [RAM_AW-1:0] ADDR_FM_INTERVAL  = RAM_AW'(12);
   localparam logic [RAM_AW-1:0] ADDR_LS_THRESHOLD = RAM_AW'(16);
   localparam logic [RAM_AW-1:0] ADDR_HUB_DESC_A   = RAM_AW'(17);

   // Port status bits.
   localparam int PS_CCS = 0;
   localparam int PS_PES = 1;
   localparam int PS_PSS = 2;
   localparam int PS_PRS = 4;
   localparam int PS_PPS = 8;
   localparam int PS_CSC = 16;
   localparam logic [DATA_W-1:0] PS_CHANGE_MASK = 32'h001f_0000;
   localparam logic [DATA_W-1:0] PS_REQUEST_MASK =
      (32'h1 << PS_PES) | (32'h1 << PS_PSS) | (32'h1 << PS_PRS);

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_REVISION,
      KIND_PLAIN,
      KIND_PORT
   } access_kind_type;

   // Value of a word that has not been written since the last reset.
   function automatic logic [DATA_W-1:0] reset_word(input logic [RAM_AW-1:0] addr,
                                                    input logic [DATA_W-1:0] desc_a);
      logic [DATA_W-1:0] value;
      value = '0;
      if (addr == ADDR_FM_INTERVAL) begin
         value = FM_INTERVAL_RESET;
      end else if (addr == ADDR_LS_THRESHOLD) begin
         value = LS_THRESHOLD_RESET;
      end else if (addr == ADDR_HUB_DESC_A) begin
         value = desc_a;
      end
      return value;
   endfunction

   // New port status word after a write of data to it.
   function automatic logic [DATA_W-1:0] port_update(input logic [DATA_W-1:0] status,
                                                     input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] req;
      s = status;
      if (data[PS_CCS]) begin
         s[PS_PES] = 1'b0;
      end
      s = s & ~(data & PS_CHANGE_MASK);
      req = data & PS_REQUEST_MASK;
      if (req != '0) begin
         if (s[PS_CCS]) begin
            s = s | req;
         end else begin
            s[PS_CSC] = 1'b1;
         end
      end
      s[PS_PPS] = 1'b1;
      return s;
   endfunction

endpackage

@@ src/uhc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module uhc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ src/usb_host_controller_register_bank_unit.sv @@
// Top level of the USB host controller register bank: decode, RAM read-modify-write, response.
//
// An item is a bus access, taken at a rising edge where start is high and busy is low.
// Only region 0 with 4-byte accesses is served; anything else answers handled low.
// The operational registers and the root hub port status words sit in one 35-word RAM
// with a registered read. The access is decoded and its word read at acceptance; in the
// following cycle (busy high) the word is modified and written back, and the response
// is registered. rsp_valid is high for exactly one cycle, registered from busy, carrying
// rsp_read_data and rsp_handled; the receiver cannot hold it off.
// An item is the RAM read followed by the write-back, and no new item is accepted while
// busy is high, so the bank cannot take an item before it is through with the last one.
// csr_write_data sets the port count whenever csr_write_enable is high; it is meant to
// change only while the bank is idle, and enters hub descriptor A only on a reset.
// Reset (synchronous, active high) and a host reset write clear one valid flag per RAM
// word at once; a word that is not valid reads as its reset value, so no clearing pass
// is needed. Reset sets the port count to one.
module usb_host_controller_register_bank_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [2:0]                  req_region,
   input  logic [3:0]                  req_access_bytes,
   input  logic [uhc_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [uhc_pkg::DATA_W-1:0]  req_write_data,
   output logic                        rsp_valid,
   output logic [uhc_pkg::DATA_W-1:0]  rsp_read_data,
   output logic                        rsp_handled,
   input  logic                        csr_write_enable,
   input  logic [uhc_pkg::PC_W-1:0]    csr_write_data
);
   import uhc_pkg::*;

   logic                  accept;
   logic                  served;
   logic                  aligned;
   logic                  plain_hit;
   logic [OFF_W-1:0]      port_off;
   logic [IDX_W-1:0]      port_idx;
   logic                  port_hit;
   logic                  is_host_reset;
   access_kind_type       kind_in;
   logic [RAM_AW-1:0]     addr_in;

   logic                  busy_ff;
   logic                  op_ff;
   logic                  served_ff;
   logic                  host_reset_ff;
   access_kind_type       kind_ff;
   logic [RAM_AW-1:0]     addr_ff;
   logic [DATA_W-1:0]     data_ff;
   logic [PC_W-1:0]       port_count_ff;
   logic [DATA_W-1:0]     desc_a_ff;
   logic [RAM_DEPTH-1:0]  valid_ff;

   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_read_data_ff;
   logic                  rsp_handled_ff;
   logic [DATA_W-1:0]     rsp_read_data_in;
   logic                  rsp_handled_in;

   logic [DATA_W-1:0]     ram_q;
   logic [DATA_W-1:0]     cur_word;
   logic                  ram_we;
   logic [DATA_W-1:0]     ram_wdata;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Decode of the offered access; it is only used when the access is accepted.
   always_comb begin
      served    = (req_region == REGION_OPERATIONAL) && (req_access_bytes == WORD_BYTES);
      aligned   = (req_byte_offset[1:0] == 2'b00);
      plain_hit = aligned && (req_byte_offset >= OFF_FIRST_REG) &&
                  (req_byte_offset <= OFF_LAST_REG);
      port_off  = req_byte_offset - PORT_BASE;
      port_idx  = port_off[OFF_W-1:2];
      port_hit  = (req_byte_offset >= PORT_BASE) && (port_idx < IDX_W'(MAX_PORTS)) &&
                  (port_idx < IDX_W'(port_count_ff));
      is_host_reset = served && (req_op == OP_WRITE) &&
                      (req_byte_offset == OFF_CMD_STATUS) && req_write_data[0];
      kind_in = KIND_NONE;
      addr_in = '0;
      if (served) begin
         if (req_byte_offset == OFF_REVISION) begin
            kind_in = KIND_REVISION;
         end else if (plain_hit) begin
            kind_in = KIND_PLAIN;
            addr_in = req_byte_offset[RAM_AW+1:2] - RAM_AW'(1);
         end else if (port_hit) begin
            kind_in = KIND_PORT;
            addr_in = RAM_AW'(PLAIN_REGS) + port_idx[RAM_AW-1:0];
         end
      end
   end

   uhc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_regs_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (addr_ff),
      .write_data   (ram_wdata),
      .read_enable  (accept),
      .read_addr    (addr_in),
      .read_data    (ram_q)
   );

   // Modify stage: the stored word, or its reset value if not written since reset.
   always_comb begin
      cur_word  = valid_ff[addr_ff] ? ram_q : reset_word(addr_ff, desc_a_ff);
      ram_we    = 1'b0;
      ram_wdata = data_ff;
      if (busy_ff && (op_ff == OP_WRITE) && !host_reset_ff) begin
         if (kind_ff == KIND_PLAIN) begin
            ram_we = 1'b1;
         end else if (kind_ff == KIND_PORT) begin
            ram_we    = 1'b1;
            ram_wdata = port_update(cur_word, data_ff);
         end
      end

      rsp_read_data_in = '0;
      if (op_ff == OP_WRITE) begin
         rsp_handled_in = served_ff;
      end else begin
         rsp_handled_in = (kind_ff != KIND_NONE);
         unique case (kind_ff)
            KIND_REVISION: rsp_read_data_in = REVISION_VALUE;
            KIND_PLAIN,
            KIND_PORT:     rsp_read_data_in = cur_word;
            default:       rsp_read_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         port_count_ff <= PC_W'(1);
         desc_a_ff     <= HUB_DESC_A_BASE | DATA_W'(1);
         valid_ff      <= '0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
         if (csr_write_enable) begin
            port_count_ff <= csr_write_data;
         end
         if (busy_ff && host_reset_ff) begin
            // Host reset: every word falls back to its reset value.
            valid_ff  <= '0;
            desc_a_ff <= HUB_DESC_A_BASE | DATA_W'(port_count_ff);
         end else if (ram_we) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         served_ff     <= served;
         host_reset_ff <= is_host_reset;
         kind_ff       <= kind_in;
         addr_ff       <= addr_in;
         data_ff       <= req_write_data;
      end
      if (busy_ff) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_handled_ff   <= rsp_handled_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_handled   = rsp_handled_ff;

   a_accept_then_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not enter the modify stage");

   a_busy_one_cycle : assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("modify stage did not hand over a response after one cycle");

   a_write_only_busy : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> busy_ff)
      else $error("RAM written outside the modify stage");

   a_data_means_handled : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_data != '0)) |-> rsp_handled)
      else $error("read data returned for an access that was not handled");

endmodule

@@ bench/bank_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts every response of the register bank and compares it with the one seen.
module bank_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_op,
   input  logic [2:0]                  req_region,
   input  logic [3:0]                  req_access_bytes,
   input  logic [uhc_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [uhc_pkg::DATA_W-1:0]  req_write_data,
   input  logic                        rsp_valid,
   input  logic [uhc_pkg::DATA_W-1:0]  rsp_read_data,
   input  logic                        rsp_handled,
   input  logic                        csr_write_enable,
   input  logic [uhc_pkg::PC_W-1:0]    csr_write_data,
   output int                          mismatches,
   output int                          outstanding
);
   import uhc_pkg::*;

   // Word numbers (offset / 4) of the plain registers that do not reset to zero.
   localparam int WORD_FM_INTERVAL  = 13;
   localparam int WORD_LS_THRESHOLD = 17;
   localparam int WORD_HUB_DESC_A   = 18;
   localparam int WORD_LAST         = 20;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              handled;
   } bus_reply_type;

   bus_reply_type     awaited_replies[$];
   logic [PC_W-1:0]   live_ports;
   logic [DATA_W-1:0] plain_word [1:WORD_LAST];
   logic [DATA_W-1:0] port_word  [0:MAX_PORTS-1];

   // Puts every register back to its reset value; the port count itself is kept.
   task automatic restore_bank();
      for (int k = 1; k <= WORD_LAST; k++) begin
         plain_word[k] = '0;
      end
      for (int i = 0; i < MAX_PORTS; i++) begin
         port_word[i] = '0;
      end
      plain_word[WORD_FM_INTERVAL]  = FM_INTERVAL_RESET;
      plain_word[WORD_LS_THRESHOLD] = LS_THRESHOLD_RESET;
      plain_word[WORD_HUB_DESC_A]   = HUB_DESC_A_BASE | DATA_W'(live_ports);
   endtask

   // Works out the reply to one bus access and applies its effect on the registers.
   task automatic perform_access(input  logic              op,
                                 input  logic [2:0]        region,
                                 input  logic [3:0]        nbytes,
                                 input  logic [OFF_W-1:0]  off,
                                 input  logic [DATA_W-1:0] data,
                                 output logic [DATA_W-1:0] rd,
                                 output logic              ok);
      int unsigned       k;
      logic [OFF_W-1:0]  rel;
      logic [IDX_W-1:0]  idx;
      logic              plain_hit;
      logic              port_hit;
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] req;
      rd = '0;
      ok = 1'b0;
      if (region == REGION_OPERATIONAL && nbytes == WORD_BYTES) begin
         k         = 32'(off >> 2);
         rel       = off - PORT_BASE;
         idx       = rel[OFF_W-1:2];
         plain_hit = off[1:0] == 2'b00 && off >= OFF_FIRST_REG && off <= OFF_LAST_REG;
         port_hit  = off >= PORT_BASE && idx < live_ports && idx < MAX_PORTS;
         if (op != OP_WRITE) begin
            if (off == OFF_REVISION) begin
               rd = REVISION_VALUE;
               ok = 1'b1;
            end else if (plain_hit) begin
               rd = plain_word[k];
               ok = 1'b1;
            end else if (port_hit) begin
               rd = port_word[idx];
               ok = 1'b1;
            end
         end else begin
            ok = 1'b1;
            if (off == OFF_CMD_STATUS && data[0]) begin
               restore_bank();
            end else if (plain_hit) begin
               plain_word[k] = data;
            end else if (port_hit) begin
               s = port_word[idx];
               if (data[PS_CCS]) begin
                  s[PS_PES] = 1'b0;
               end
               s = s & ~(data & PS_CHANGE_MASK);
               req = data & PS_REQUEST_MASK;
               // A request on a port with nothing connected only flags a connect change.
               if (req != '0) begin
                  if (s[PS_CCS]) begin
                     s = s | req;
                  end else begin
                     s[PS_CSC] = 1'b1;
                  end
               end
               s[PS_PPS] = 1'b1;
               port_word[idx] = s;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      int                errs;
      bus_reply_type     want;
      logic [DATA_W-1:0] rd;
      logic              ok;
      errs = 0;
      if (reset) begin
         live_ports = PC_W'(1);
         restore_bank();
         awaited_replies.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               $error("response with no access outstanding: read_data %h handled %0d",
                      rsp_read_data, rsp_handled);
               errs++;
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
                  errs++;
               end
               if (rsp_handled !== want.handled) begin
                  $error("handled: expected %0d, actual %0d", want.handled, rsp_handled);
                  errs++;
               end
            end
         end
         if (start && !busy) begin
            perform_access(req_op, req_region, req_access_bytes, req_byte_offset,
                           req_write_data, rd, ok);
            awaited_replies.push_back(bus_reply_type'{read_data: rd, handled: ok});
         end
         // The port count changes only when the bank is idle, so no access sees it half-way.
         if (csr_write_enable) begin
            live_ports = csr_write_data;
         end
         outstanding <= awaited_replies.size();
         mismatches <= mismatches + errs;
      end
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the register bank testbench: clock, reset, bus accesses, port count changes and verdict.
module testbench;
   import uhc_pkg::*;

   localparam logic             OP_READ          = ~OP_WRITE;
   localparam logic [2:0]       REGION_LAST      = 3'd5;
   localparam logic [3:0]       SIZE_BYTE        = 4'd1;
   localparam logic [3:0]       SIZE_DWORD       = 4'd8;
   localparam logic [OFF_W-1:0] OFF_CONTROL      = 12'h004;
   localparam logic [OFF_W-1:0] OFF_HCCA         = 12'h018;
   localparam logic [OFF_W-1:0] OFF_FM_INTERVAL  = 12'h034;
   localparam logic [OFF_W-1:0] OFF_LS_THRESHOLD = 12'h044;
   localparam logic [OFF_W-1:0] OFF_HUB_DESC_A   = 12'h048;
   localparam logic [OFF_W-1:0] OFF_TOP          = 12'hfff;
   localparam logic [DATA_W-1:0] PORT_BITS       = 32'h001f_0117;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 210;

   logic              clock;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic              req_op           = 1'b0;
   logic [2:0]        req_region       = '0;
   logic [3:0]        req_access_bytes = '0;
   logic [OFF_W-1:0]  req_byte_offset  = '0;
   logic [DATA_W-1:0] req_write_data   = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_handled;
   logic              csr_write_enable = 1'b0;
   logic [PC_W-1:0]   csr_write_data   = '0;
   int                mismatches;
   int                outstanding;
   int                issued = 0;

   usb_host_controller_register_bank_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_region       (req_region),
      .req_access_bytes (req_access_bytes),
      .req_byte_offset  (req_byte_offset),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_handled      (rsp_handled),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bank_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_region       (req_region),
      .req_access_bytes (req_access_bytes),
      .req_byte_offset  (req_byte_offset),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_handled      (rsp_handled),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Presents one item and returns at the edge that takes it. Gaps are skipped in a calm stretch.
   task automatic issue_access(input logic              op,
                               input logic [2:0]        region,
                               input logic [3:0]        nbytes,
                               input logic [OFF_W-1:0]  off,
                               input logic [DATA_W-1:0] data);
      if (!(issued >= 700 && issued < 1000) && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start            <= 1'b1;
      req_op           <= op;
      req_region       <= region;
      req_access_bytes <= nbytes;
      req_byte_offset  <= off;
      req_write_data   <= data;
      do @(posedge clock); while (busy);
      issued++;
   endtask

   task automatic read_word(input logic [OFF_W-1:0] off);
      issue_access(OP_READ, REGION_OPERATIONAL, WORD_BYTES, off, $urandom);
   endtask

   task automatic write_word(input logic [OFF_W-1:0] off, input logic [DATA_W-1:0] data);
      issue_access(OP_WRITE, REGION_OPERATIONAL, WORD_BYTES, off, data);
   endtask

   // Holds the bus quiet until every response is back, then lets the pipeline settle.
   task automatic drain_bank();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_access();
      logic              op;
      logic [2:0]        region;
      logic [3:0]        nbytes;
      logic [OFF_W-1:0]  off;
      logic [DATA_W-1:0] data;
      int unsigned       pick;
      op     = 1'($urandom_range(0, 1));
      data   = $urandom;
      region = REGION_OPERATIONAL;
      nbytes = WORD_BYTES;
      pick   = $urandom_range(0, 99);
      if (pick < 8) begin
         region = 3'($urandom_range(0, REGION_LAST));
         nbytes = 4'($urandom_range(SIZE_BYTE, SIZE_DWORD));
         off    = OFF_W'($urandom_range(0, 4095));
      end else if (pick < 45) begin
         // Two words past the last port, so absent ports are reached at every port count.
         off = OFF_W'(PORT_BASE + 4 * $urandom_range(0, MAX_PORTS + 1));
         if ($urandom_range(0, 1) == 1) begin
            data = data & PORT_BITS;
         end
      end else if (pick < 75) begin
         off = OFF_W'(4 * $urandom_range(0, 20));
      end else if (pick < 85) begin
         off = OFF_W'($urandom_range(0, 12'h0a0));
      end else if (pick < 92) begin
         off = OFF_W'($urandom_range(0, 4095));
      end else begin
         off = OFF_CMD_STATUS;
      end
      // Host resets wipe everything, so most command writes leave that bit clear.
      if (off == OFF_CMD_STATUS && $urandom_range(0, 9) != 0) begin
         data[0] = 1'b0;
      end
      issue_access(op, region, nbytes, off, data);
   endtask

   initial begin
      logic [PC_W-1:0] port_setting [PHASES];
      port_setting = '{4'd15, 4'd0, 4'd7, 4'd1, 4'd15, 4'd2, 4'd9, 4'd1};
      port_setting[6] = PC_W'($urandom_range(1, 15));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_word(OFF_REVISION);
      write_word(OFF_REVISION, 32'hffff_ffff);
      read_word(OFF_REVISION);
      read_word(OFF_CONTROL);
      write_word(OFF_HCCA, 32'hffff_ffff);
      read_word(OFF_HCCA);
      read_word(OFF_FM_INTERVAL);
      read_word(OFF_LS_THRESHOLD);
      read_word(OFF_HUB_DESC_A);
      read_word(OFF_CONTROL + 12'd1);
      issue_access(OP_READ, REGION_LAST, WORD_BYTES, OFF_HCCA, '0);
      issue_access(OP_READ, REGION_OPERATIONAL, SIZE_BYTE, OFF_HCCA, '0);
      issue_access(OP_WRITE, REGION_OPERATIONAL, SIZE_DWORD, OFF_HCCA, '0);
      read_word(OFF_HCCA);
      write_word(PORT_BASE, 32'hffff_ffff);
      read_word(PORT_BASE);
      write_word(PORT_BASE, 32'h0000_0016);
      read_word(PORT_BASE + 12'd3);
      read_word(PORT_BASE + 12'd4);
      write_word(OFF_TOP, 32'ha5a5_5a5a);
      read_word(OFF_TOP);
      write_word(OFF_CMD_STATUS, 32'hffff_fffe);
      read_word(OFF_CMD_STATUS);
      write_word(OFF_CMD_STATUS, 32'h0000_0001);
      read_word(OFF_HCCA);
      read_word(PORT_BASE);

      for (int p = 0; p < PHASES; p++) begin
         drain_bank();
         csr_write_enable <= 1'b1;
         csr_write_data   <= port_setting[p];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         // The new count reaches descriptor A only through a host reset.
         read_word(OFF_HUB_DESC_A);
         write_word(OFF_CMD_STATUS, $urandom | 32'h1);
         read_word(OFF_HUB_DESC_A);
         repeat (ITEMS_PER_PHASE) random_access();
      end
      drain_bank();

      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
